>>> hdl/mngs_pkg.sv
// ----------------------------------------------------------------------------
// mngs_pkg
// Shared types and constants of the normal-guided mesh smoothing unit.
// ----------------------------------------------------------------------------
package mngs_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int IDX_W        = 10;
  localparam int POS_W        = 16;
  localparam int ACC_W        = 24;
  localparam int AMT_W        = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  // action codes
  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_TRI  = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_AMOUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INC_EDGE = 2'd1;

  localparam logic [AMT_W-1:0] AMOUNT_RST = 16'd6554;

  // floor(s/3) for -3*2^15 <= s < 3*2^15: offset by 3*2^15, reciprocal multiply, shift
  localparam int DIV3_OFS = 98304;
  localparam int DIV3_MUL = 699051;
  localparam int DIV3_SH  = 21;

  typedef struct packed {
    logic [1:0]              action;
    logic [IDX_W-1:0]        vertex_index;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [POS_W-1:0] norm_x;
    logic signed [POS_W-1:0] norm_y;
    logic signed [POS_W-1:0] norm_z;
    logic                    edge_flag;
    logic [IDX_W-1:0]        corner_a;
    logic [IDX_W-1:0]        corner_b;
    logic [IDX_W-1:0]        corner_c;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]        out_index;
    logic signed [POS_W-1:0] out_x;
    logic signed [POS_W-1:0] out_y;
    logic signed [POS_W-1:0] out_z;
    logic                    was_moved;
  } out_word_t;

  // vertex memory entry, axis 0 is x
  typedef struct packed {
    logic                   edge_f;
    logic [2:0][POS_W-1:0]  nrm;
    logic [2:0][POS_W-1:0]  pos;
  } vtx_t;

  typedef logic [2:0][ACC_W-1:0] acc_t;

endpackage

>>> hdl/mngs_ram.sv
// ----------------------------------------------------------------------------
// mngs_ram
// Generic RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module mngs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hdl/mesh_normal_guided_smoothing_unit.sv
// ----------------------------------------------------------------------------
// mesh_normal_guided_smoothing_unit
// Vertex store with normal-guided smoothing accumulators.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. A load leaves busy
// low. A read raises busy for state S_RDOUT, in which its result is
// registered; it then shows on out_data with out_valid, is there for one
// cycle only and cannot be held off. A triangle keeps busy high from S_RB to
// its last S_ACC: S_RB, S_RC and S_CAPC capture the corners read out of the
// vertex memory, S_MID forms the midpoint, and each corner then passes S_DOT,
// S_SUM, S_TMUL, S_SMUL and S_ACC through the shared multiply chain and the
// read-modify-write of its accumulator entry. Configuration writes are always
// taken (cfg_ready is high) and belong to idle periods.
module mesh_normal_guided_smoothing_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  mngs_pkg::in_word_t                 in_data,
  output logic                               out_valid,
  output mngs_pkg::out_word_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mngs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mngs_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mngs_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_RDOUT = 11'b000_0000_0010,
    S_RB    = 11'b000_0000_0100,
    S_RC    = 11'b000_0000_1000,
    S_CAPC  = 11'b000_0001_0000,
    S_MID   = 11'b000_0010_0000,
    S_DOT   = 11'b000_0100_0000,
    S_SUM   = 11'b000_1000_0000,
    S_TMUL  = 11'b001_0000_0000,
    S_SMUL  = 11'b010_0000_0000,
    S_ACC   = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [AMT_W-1:0] amount_r;
  logic             inc_edge_r;

  logic [2:0][ADDR_W-1:0]        cor_r;
  logic [1:0]                    k_r;
  logic [2:0][2:0][POS_W-1:0]    pos_r;
  logic [2:0][2:0][POS_W-1:0]    nrm_r;
  logic [2:0][POS_W-1:0]         mid_r;
  logic signed [18:0]            nd_r   [3];
  logic signed [20:0]            dot_r;
  logic signed [22:0]            t_r    [3];
  logic signed [23:0]            step_r [3];
  out_word_t                     out_r;
  logic                          out_valid_r;

  // memory ports
  logic              vwr_en, awr_en;
  logic [ADDR_W-1:0] vwr_addr, vrd_addr, awr_addr, ard_addr;
  vtx_t              vwr_data, vrd_data;
  acc_t              awr_data, ard_data;

  logic accept;
  assign accept = start && (state_r == S_IDLE);

  // datapath
  logic signed [17:0] sum3 [3];
  logic        [17:0] u3   [3];
  logic        [37:0] q3   [3];
  logic signed [16:0] dif  [3];
  logic signed [32:0] ndp  [3];
  logic signed [36:0] tp   [3];
  logic signed [39:0] sp   [3];
  logic signed [24:0] asum [3];
  acc_t               acc_new;
  logic signed [20:0] dot_sum;
  logic               moved;
  out_word_t          out_nxt;
  logic [2:0][POS_W-1:0] rd_pos;

  function automatic logic [ACC_W-1:0] sat24(input logic signed [24:0] v);
    logic [ACC_W-1:0] r;
    if (v[24] != v[23]) begin
      r = {v[24], {(ACC_W-1){~v[24]}}};
    end else begin
      r = v[ACC_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [POS_W-1:0] sat16(input logic [ACC_W-1:0] v);
    logic [POS_W-1:0] r;
    if ((&v[ACC_W-1:POS_W-1]) || !(|v[ACC_W-1:POS_W-1])) begin
      r = v[POS_W-1:0];
    end else begin
      r = {v[ACC_W-1], {(POS_W-1){~v[ACC_W-1]}}};
    end
    return r;
  endfunction

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sum3[a] = 18'($signed(pos_r[0][a])) + 18'($signed(pos_r[1][a]))
              + 18'($signed(pos_r[2][a]));
      u3[a]   = 18'(sum3[a] + 18'(DIV3_OFS));
      q3[a]   = 38'(u3[a]) * 38'(DIV3_MUL);
      dif[a]  = 17'($signed(mid_r[a])) - 17'($signed(pos_r[k_r][a]));
      ndp[a]  = 33'($signed(nrm_r[k_r][a])) * 33'(dif[a]);
      tp[a]   = 37'($signed(nrm_r[k_r][a])) * 37'(dot_r);
      sp[a]   = 40'(t_r[a]) * 40'($signed({1'b0, amount_r}));
      asum[a] = 25'($signed(ard_data[a])) + 25'(step_r[a]);
      acc_new[a] = sat24(asum[a]);
    end
    dot_sum = 21'(nd_r[0]) + 21'(nd_r[1]) + 21'(nd_r[2]);

    moved = inc_edge_r || !vrd_data.edge_f;
    for (int a = 0; a < 3; a++) begin
      rd_pos[a] = moved ? sat16(ard_data[a]) : vrd_data.pos[a];
    end
    out_nxt.out_index = out_r.out_index;
    out_nxt.out_x     = $signed(rd_pos[0]);
    out_nxt.out_y     = $signed(rd_pos[1]);
    out_nxt.out_z     = $signed(rd_pos[2]);
    out_nxt.was_moved = moved;
  end

  // memory port control
  always_comb begin
    vwr_en   = accept && (in_data.action == ACT_LOAD);
    vwr_addr = ADDR_W'(in_data.vertex_index);
    vwr_data.edge_f = in_data.edge_flag;
    vwr_data.nrm    = {in_data.norm_z, in_data.norm_y, in_data.norm_x};
    vwr_data.pos    = {in_data.pos_z, in_data.pos_y, in_data.pos_x};

    case (state_r)
      S_RB:    vrd_addr = cor_r[1];
      S_RC:    vrd_addr = cor_r[2];
      default: vrd_addr = (in_data.action == ACT_TRI) ? ADDR_W'(in_data.corner_a)
                                                      : ADDR_W'(in_data.vertex_index);
    endcase

    ard_addr = (state_r == S_SMUL) ? cor_r[k_r] : ADDR_W'(in_data.vertex_index);

    if (state_r == S_ACC) begin
      awr_en   = 1'b1;
      awr_addr = cor_r[k_r];
      awr_data = acc_new;
    end else begin
      awr_en   = vwr_en;
      awr_addr = vwr_addr;
      for (int a = 0; a < 3; a++) begin
        awr_data[a] = ACC_W'($signed(vwr_data.pos[a]));
      end
    end
  end

  mngs_ram #(.WIDTH($bits(vtx_t)), .DEPTH(MAX_VERTICES)) u_vtx_ram (
    .clk     (clk),
    .wr_en   (vwr_en),
    .wr_addr (vwr_addr),
    .wr_data (vwr_data),
    .rd_addr (vrd_addr),
    .rd_data (vrd_data)
  );

  mngs_ram #(.WIDTH($bits(acc_t)), .DEPTH(MAX_VERTICES)) u_acc_ram (
    .clk     (clk),
    .wr_en   (awr_en),
    .wr_addr (awr_addr),
    .wr_data (awr_data),
    .rd_addr (ard_addr),
    .rd_data (ard_data)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && in_data.action == ACT_READ) begin
          state_nxt = S_RDOUT;
        end else if (accept && in_data.action == ACT_TRI) begin
          state_nxt = S_RB;
        end
      end
      S_RDOUT: state_nxt = S_IDLE;
      S_RB:    state_nxt = S_RC;
      S_RC:    state_nxt = S_CAPC;
      S_CAPC:  state_nxt = S_MID;
      S_MID:   state_nxt = S_DOT;
      S_DOT:   state_nxt = S_SUM;
      S_SUM:   state_nxt = S_TMUL;
      S_TMUL:  state_nxt = S_SMUL;
      S_SMUL:  state_nxt = S_ACC;
      S_ACC:   state_nxt = (k_r == 2'd2) ? S_IDLE : S_DOT;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      amount_r    <= AMOUNT_RST;
      inc_edge_r  <= 1'b0;
      out_valid_r <= 1'b0;
      k_r         <= 2'd0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_RDOUT);
      if (cfg_valid && cfg_index == CFG_AMOUNT) begin
        amount_r <= cfg_data[AMT_W-1:0];
      end
      if (cfg_valid && cfg_index == CFG_INC_EDGE) begin
        inc_edge_r <= cfg_data[0];
      end
      if (state_r == S_MID) begin
        k_r <= 2'd0;
      end else if (state_r == S_ACC) begin
        k_r <= k_r + 2'd1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      out_r.out_index <= in_data.vertex_index;
      cor_r <= {ADDR_W'(in_data.corner_c), ADDR_W'(in_data.corner_b),
                ADDR_W'(in_data.corner_a)};
    end
    case (state_r)
      S_RB: begin
        pos_r[0] <= vrd_data.pos;
        nrm_r[0] <= vrd_data.nrm;
      end
      S_RC: begin
        pos_r[1] <= vrd_data.pos;
        nrm_r[1] <= vrd_data.nrm;
      end
      S_CAPC: begin
        pos_r[2] <= vrd_data.pos;
        nrm_r[2] <= vrd_data.nrm;
      end
      S_RDOUT: out_r <= out_nxt;
      S_MID: begin
        // midpoint = floor(sum/3) = q - 2^15 with q in [0, 2^16)
        for (int a = 0; a < 3; a++) begin
          mid_r[a] <= {~q3[a][DIV3_SH+POS_W-1], q3[a][DIV3_SH +: POS_W-1]};
        end
      end
      S_DOT: begin
        for (int a = 0; a < 3; a++) begin
          nd_r[a] <= ndp[a][32:14];
        end
      end
      S_SUM: dot_r <= dot_sum;
      S_TMUL: begin
        for (int a = 0; a < 3; a++) begin
          t_r[a] <= tp[a][36:14];
        end
      end
      S_SMUL: begin
        for (int a = 0; a < 3; a++) begin
          step_r[a] <= sp[a][39:16];
        end
      end
      default: ;
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

endmodule

>>> hdl/mngs_checker.sv
// ----------------------------------------------------------------------------
// mngs_checker
// Port-level checks of the smoothing unit, bound to the top level.
// ----------------------------------------------------------------------------
module mngs_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input mngs_pkg::in_word_t              in_data,
  input logic                            out_valid,
  input mngs_pkg::out_word_t             out_data,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [mngs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [mngs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mngs_pkg::*;

  logic rd_take, ld_take;
  assign rd_take = start && !busy && in_data.action == ACT_READ;
  assign ld_take = start && !busy && in_data.action == ACT_LOAD;

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    rd_take |-> ##2 out_valid) else $error("read word gave no result");

  a_read_index: assert property (@(posedge clk) disable iff (!rst_n)
    rd_take |-> ##2 (out_data.out_index == $past(in_data.vertex_index, 2)))
    else $error("result index does not match read");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held two cycles");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    ld_take |=> !busy && !out_valid) else $error("load stalled or made a result");

endmodule

bind mesh_normal_guided_smoothing_unit mngs_checker u_mngs_checker (.*);

>>> tb/sv/tb_mesh_normal_guided_smoothing_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mesh_normal_guided_smoothing_unit
// Self-checking bench for the normal-guided smoothing unit. A queue-fed
// driver issues load, triangle, read and unused-action words with random
// gaps, and a bit-exact predictor of the vertex store and accumulators
// gives the expected read results. A monitor checks every field of them.
// The run goes through several register settings, each written while
// the unit is idle.
// ----------------------------------------------------------------------------
module tb_mesh_normal_guided_smoothing_unit;
  import mngs_pkg::*;

  localparam int WDOG_LIMIT  = 3000;
  localparam int DRAIN_WAIT  = 40;
  localparam int POOL_N      = 12;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_word_t              in_data;
  logic                  out_valid;
  out_word_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mesh_normal_guided_smoothing_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  longint    vtx_pos [MAX_VERTICES][3];
  longint    vtx_nrm [MAX_VERTICES][3];
  bit        vtx_edge[MAX_VERTICES];
  longint    vtx_acc [MAX_VERTICES][3];
  logic [15:0] amount_r;
  bit          inc_edges_r;

  in_word_t  cmd_q[$];
  out_word_t read_expect_q[$];
  bit        loaded[MAX_VERTICES];
  int        pool[POOL_N];
  int        err_cnt;
  int        gap_left;
  bit        calm_mode;
  int        wdog;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint floor_div3(longint s);
    if (s >= 0) return s / 3;
    return -((-s + 2) / 3);
  endfunction

  function automatic void smooth_model_step(in_word_t w);
    int        c[3];
    longint    mid[3];
    longint    stp[3][3];
    longint    dot, d, t;
    int        s;
    bit        moved;
    out_word_t r;
    s = int'(w.vertex_index);
    case (w.action)
      ACT_LOAD: begin
        vtx_pos[s][0] = w.pos_x;  vtx_pos[s][1] = w.pos_y;  vtx_pos[s][2] = w.pos_z;
        vtx_nrm[s][0] = w.norm_x; vtx_nrm[s][1] = w.norm_y; vtx_nrm[s][2] = w.norm_z;
        for (int ax = 0; ax < 3; ax++) vtx_acc[s][ax] = vtx_pos[s][ax];
        vtx_edge[s] = w.edge_flag;
      end
      ACT_TRI: begin
        c[0] = int'(w.corner_a); c[1] = int'(w.corner_b); c[2] = int'(w.corner_c);
        for (int ax = 0; ax < 3; ax++)
          mid[ax] = floor_div3(vtx_pos[c[0]][ax] + vtx_pos[c[1]][ax] + vtx_pos[c[2]][ax]);
        for (int k = 0; k < 3; k++) begin
          dot = 0;
          for (int ax = 0; ax < 3; ax++) begin
            d = mid[ax] - vtx_pos[c[k]][ax];
            dot += (vtx_nrm[c[k]][ax] * d) >>> 14;
          end
          for (int ax = 0; ax < 3; ax++) begin
            t = (vtx_nrm[c[k]][ax] * dot) >>> 14;
            stp[k][ax] = (t * longint'(amount_r)) >>> 16;
          end
        end
        // corners applied after all steps are formed; repeated corners add twice
        for (int k = 0; k < 3; k++)
          for (int ax = 0; ax < 3; ax++)
            vtx_acc[c[k]][ax] = clamp(vtx_acc[c[k]][ax] + stp[k][ax], -8388608, 8388607);
      end
      ACT_READ: begin
        moved = inc_edges_r || !vtx_edge[s];
        r.out_index = w.vertex_index;
        r.was_moved = moved;
        r.out_x = moved ? 16'(clamp(vtx_acc[s][0], -32768, 32767)) : 16'(vtx_pos[s][0]);
        r.out_y = moved ? 16'(clamp(vtx_acc[s][1], -32768, 32767)) : 16'(vtx_pos[s][1]);
        r.out_z = moved ? 16'(clamp(vtx_acc[s][2], -32768, 32767)) : 16'(vtx_pos[s][2]);
        read_expect_q = {read_expect_q, r};
      end
      default: ;
    endcase
  endfunction

  // ---------------- stimulus builders ----------------
  function automatic in_word_t noise_word();
    in_word_t     w;
    logic [159:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    w = raw[$bits(in_word_t)-1:0];
    return w;
  endfunction

  function automatic int rand_norm();
    case ($urandom_range(0, 9))
      0:       return 16384;
      1:       return -16384;
      default: return int'($urandom_range(0, 32768)) - 16384;
    endcase
  endfunction

  function automatic void push_load(int idx, int px, int py, int pz,
                                    int nx, int ny, int nz, bit e);
    in_word_t w;
    w = noise_word();
    w.action = ACT_LOAD; w.vertex_index = idx[9:0];
    w.pos_x = px[15:0]; w.pos_y = py[15:0]; w.pos_z = pz[15:0];
    w.norm_x = nx[15:0]; w.norm_y = ny[15:0]; w.norm_z = nz[15:0];
    w.edge_flag = e;
    loaded[idx] = 1'b1;
    cmd_q = {cmd_q, w};
  endfunction

  function automatic void push_rand_load(int idx);
    push_load(idx, $urandom, $urandom, $urandom, rand_norm(), rand_norm(), rand_norm(),
              1'($urandom_range(0, 1)));
  endfunction

  function automatic void push_tri(int a, int b, int c);
    in_word_t w;
    w = noise_word();
    w.action = ACT_TRI;
    w.corner_a = a[9:0]; w.corner_b = b[9:0]; w.corner_c = c[9:0];
    cmd_q = {cmd_q, w};
  endfunction

  function automatic void push_read(int idx);
    in_word_t w;
    w = noise_word();
    w.action = ACT_READ; w.vertex_index = idx[9:0];
    cmd_q = {cmd_q, w};
  endfunction

  // mostly a small hot pool so accumulators build up
  function automatic int pick_loaded();
    int idx;
    if ($urandom_range(0, 9) < 8) return pool[$urandom_range(0, POOL_N - 1)];
    do idx = $urandom_range(0, MAX_VERTICES - 1); while (!loaded[idx]);
    return idx;
  endfunction

  function automatic void random_phase(int n);
    int r, idx;
    in_word_t w;
    for (int i = 0; i < POOL_N; i++) push_rand_load(pool[i]);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        idx = ($urandom_range(0, 3) == 0) ? pool[$urandom_range(0, POOL_N - 1)]
                                          : $urandom_range(0, MAX_VERTICES - 1);
        push_rand_load(idx);
      end else if (r < 65) begin
        push_tri(pick_loaded(), pick_loaded(), pick_loaded());
      end else if (r < 97) begin
        push_read(pick_loaded());
      end else begin
        w = noise_word();
        w.action = 2'd3;
        cmd_q = {cmd_q, w};
        i--;
      end
    end
  endfunction

  // ---------------- driver ----------------
  always @(posedge clk) begin
    bit nxt_start;
    if (!rst_n) begin
      start    <= 1'b0;
      gap_left = 0;
    end else begin
      nxt_start = start;
      if (start && !busy) begin
        smooth_model_step(in_data);
        if ($urandom_range(0, 199) == 0) calm_mode = !calm_mode;
        if (calm_mode) gap_left = 0;
        else case ($urandom_range(0, 19))
          0:       gap_left = $urandom_range(10, 60);
          1, 2, 3: gap_left = $urandom_range(1, 4);
          default: gap_left = 0;
        endcase
        nxt_start = 1'b0;
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          nxt_start = 1'b0;
        end else if (cmd_q.size() > 0) begin
          in_data <= cmd_q.pop_front();
          nxt_start = 1'b1;
        end
      end
      start <= nxt_start;
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid) begin
      if (read_expect_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("ERROR: unexpected read word idx=%0d", out_data.out_index);
      end else begin
        e = read_expect_q.pop_front();
        if (out_data !== e) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("ERROR: read mismatch exp idx=%0d x=%0d y=%0d z=%0d mv=%0b",
                     e.out_index, e.out_x, e.out_y, e.out_z, e.was_moved);
            $display("       got idx=%0d x=%0d y=%0d z=%0d mv=%0b",
                     out_data.out_index, out_data.out_x, out_data.out_y,
                     out_data.out_z, out_data.was_moved);
          end
        end
      end
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_AMOUNT) amount_r = val;
    else if (idx == CFG_INC_EDGE) inc_edges_r = val[0];
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (cmd_q.size() != 0 || start || gap_left != 0 || read_expect_q.size() != 0);
    // triangles finish with no result; let them drain
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    err_cnt   = 0;
    gap_left  = 0;
    wdog      = 0;
    calm_mode = 1'b0;
    amount_r    = AMOUNT_RST;
    inc_edges_r = 1'b0;
    for (int i = 0; i < MAX_VERTICES; i++) loaded[i] = 1'b0;
    for (int i = 0; i < POOL_N; i++) pool[i] = $urandom_range(0, MAX_VERTICES - 1);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, repeated corner, edge vertex, unused action
    push_load(0, 32767, -32768, 0, 16384, -16384, 0, 1'b0);
    push_load(1023, -32768, 32767, -32768, -16384, 16384, 16384, 1'b1);
    push_load(5, 0, 0, 32767, 0, 0, -16384, 1'b0);
    push_load(6, 256, -256, 1, 11585, 11585, 0, 1'b1);
    push_read(0);
    push_read(1023);
    push_tri(0, 1023, 5);
    push_tri(5, 5, 0);
    push_tri(6, 6, 6);
    push_read(0);
    push_read(1023);
    push_read(5);
    push_read(6);
    begin
      in_word_t w;
      w = noise_word();
      w.action = 2'd3;
      cmd_q = {cmd_q, w};
    end
    push_read(5);
    wait_idle();

    cfg_write(CFG_INC_EDGE, 16'h0001);
    cfg_write(CFG_AMOUNT, 16'hFFFF);
    // hammer one triangle to drive accumulators into saturation
    for (int i = 0; i < 70; i++) push_tri(0, 1023, 5);
    push_read(0); push_read(1023); push_read(5); push_read(6);
    random_phase(200);
    wait_idle();

    cfg_write(CFG_AMOUNT, 16'h0000);
    cfg_write(CFG_INC_EDGE, 16'hFFFE);
    random_phase(200);
    wait_idle();

    cfg_write(CFG_AMOUNT, 16'($urandom));
    cfg_write(CFG_INC_EDGE, 16'h0001);
    random_phase(200);
    wait_idle();

    cfg_write(CFG_AMOUNT, 16'h0001);
    cfg_write(CFG_INC_EDGE, 16'h0000);
    random_phase(150);
    wait_idle();

    cfg_write(CFG_AMOUNT, 16'hFFFF);
    cfg_write(CFG_INC_EDGE, 16'($urandom));
    random_phase(200);
    wait_idle();

    if (err_cnt == 0 && read_expect_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
